FILE: design/lbp_pkg.sv
`timescale 1ns / 1ps
// lbp_pkg: shared widths and the slot entry type of the binding pool.
// No dependencies; used by lbp_slot_mem, lru_binding_pool and lbp_checker.
package lbp_pkg;

  localparam int KEY_W      = 64;
  localparam int STAMP_W    = 64;
  localparam int HANDLE_W   = 32;
  localparam int SLOT_OUT_W = 4;
  localparam int CAP_W      = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // One pool entry as kept in the slot memory.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } lbp_entry_t;

endpackage

FILE: design/lbp_slot_mem.sv
`timescale 1ns / 1ps
// lbp_slot_mem: key/stamp store of the binding pool, one read and one write port.
// Depends on lbp_pkg (lbp_entry_t). Read data is registered.
module lbp_slot_mem
  import lbp_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output lbp_entry_t    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  lbp_entry_t    wr_data
);

  lbp_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/lru_binding_pool.sv
`timescale 1ns / 1ps
// lru_binding_pool: fully associative LRU pool of format keys, top level.
// Depends on lbp_pkg and lbp_slot_mem.
//
//  channel   | signals                          | dir | notes
//  ----------+----------------------------------+-----+------------------------------
//  request   | in_valid in_ready format_key     | in  | one item in flight at a time
//            | index_handle                     |     |
//  result    | out_valid out_ready slot hit ... | out | registered, holds while stalled
//  config    | cfg_we cfg_data                  | in  | pool_capacity, write only
//
// Sequence: S_IDLE accepts an item, S_SCAN issues one memory read per filled
// slot, S_LAST drains the read pipe and S_WRITE writes back, waiting while the
// previous result is held; an empty pool skips scan and drain. The single read
// port of the slot memory sets the length of the scan.
// Reset: pool empty, nothing bound, use counter zero, capacity 16. The slot
// memory is not cleared; only entries below the fill count are ever read.
// Stalls: the result register frees the input side; a new item is taken while a
// result waits, and write-back waits only if the previous result is still held.
module lru_binding_pool
  import lbp_pkg::*;
#(
  parameter int MAX_SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CAP_W-1:0]      cfg_data,
  // request
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KEY_W-1:0]      format_key,
  input  logic [HANDLE_W-1:0]   index_handle,
  // result
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SLOT_OUT_W-1:0] slot,
  output logic                  hit,
  output logic                  evicted,
  output logic                  bind_changed,
  output logic                  invalidate_index_cache,
  output logic                  define_needed,
  output logic [HANDLE_W-1:0]   bind_index_handle
);

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int EW     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int SX     = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_LAST  = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [1:0]          state;
  logic [CAP_W-1:0]    cap_reg;
  logic [CNT_W-1:0]    filled;
  logic [STAMP_W-1:0]  use_counter;
  logic [SLOT_W-1:0]   bound_slot;
  logic                bound_valid;

  // request held for the duration of the scan
  logic [KEY_W-1:0]    req_key;
  logic [HANDLE_W-1:0] req_handle;

  // scan pointer and compare stage
  logic [SLOT_W-1:0]   ptr;
  logic                cmp_valid;
  logic [SLOT_W-1:0]   cmp_addr;
  logic                found;
  logic [SLOT_W-1:0]   match_slot;
  logic [STAMP_W-1:0]  best_stamp;
  logic [SLOT_W-1:0]   lru_slot;

  lbp_entry_t          rd_entry;
  lbp_entry_t          wr_entry;
  logic                rd_en;
  logic                wr_en;
  logic                accept;
  logic                ptr_last;

  // write-back decision
  logic [EW-1:0]       cap_w;
  logic [EW-1:0]       cap_eff;
  logic                has_room;
  logic [SLOT_W-1:0]   sel_slot;
  logic                sel_evict;
  logic                sel_changed;
  logic [STAMP_W-1:0]  use_counter_next;
  logic [SX-1:0]       sel_slot_wide;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign rd_en    = (state == S_SCAN);
  assign ptr_last = ((CNT_W'(ptr) + CNT_W'(1)) == filled);
  // write-back fires once the result register is free
  assign wr_en    = (state == S_WRITE) && (!out_valid || out_ready);

  // capacity clamped to 1..MAX_SLOTS
  always_comb begin
    cap_w = EW'(cap_reg);
    priority if (cap_w == '0) begin
      cap_eff = EW'(1);
    end else if (cap_w > EW'(MAX_SLOTS)) begin
      cap_eff = EW'(MAX_SLOTS);
    end else begin
      cap_eff = cap_w;
    end
  end

  always_comb begin
    has_room         = (EW'(filled) < cap_eff);
    sel_evict        = !found && !has_room;
    use_counter_next = use_counter + STAMP_W'(1);
    priority if (found) begin
      sel_slot = match_slot;
    end else if (has_room) begin
      sel_slot = filled[SLOT_W-1:0];
    end else begin
      sel_slot = lru_slot;
    end
    sel_changed    = !bound_valid || (bound_slot != sel_slot);
    sel_slot_wide  = SX'(sel_slot);
    wr_entry.key   = req_key;
    wr_entry.stamp = use_counter_next;
  end

  lbp_slot_mem #(
    .DEPTH (MAX_SLOTS),
    .AW    (SLOT_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (ptr),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr (sel_slot),
    .wr_data (wr_entry)
  );

  // Sequencer: scan every filled slot, drain the last read, then write back.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ptr <= '0;
            if (filled == '0) begin
              state <= S_WRITE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          ptr <= ptr + SLOT_W'(1);
          if (ptr_last) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (wr_en) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_key    <= format_key;
      req_handle <= index_handle;
    end
  end

  // Compare stage: first key match in slot order, smallest stamp with lowest
  // slot winning ties (strict less-than keeps the earlier slot).
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      cmp_valid <= rd_en;
      if (accept) begin
        found <= 1'b0;
      end else if (cmp_valid && !found && (rd_entry.key == req_key)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_addr <= ptr;
    if (cmp_valid && !found && (rd_entry.key == req_key)) begin
      match_slot <= cmp_addr;
    end
    if (cmp_valid && ((cmp_addr == '0) || (rd_entry.stamp < best_stamp))) begin
      best_stamp <= rd_entry.stamp;
      lru_slot   <= cmp_addr;
    end
  end

  // Pool state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg     <= CAP_RESET;
      filled      <= '0;
      use_counter <= '0;
      bound_slot  <= '0;
      bound_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_reg <= cfg_data;
      end
      if (wr_en) begin
        use_counter <= use_counter_next;
        bound_slot  <= sel_slot;
        bound_valid <= 1'b1;
        if (!found && has_room) begin
          filled <= filled + CNT_W'(1);
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot                   <= sel_slot_wide[SLOT_OUT_W-1:0];
      hit                    <= found;
      evicted                <= sel_evict;
      bind_changed           <= sel_changed;
      invalidate_index_cache <= !found || sel_changed;
      define_needed          <= !found;
      bind_index_handle      <= req_handle;
    end
  end

endmodule

FILE: design/lbp_checker.sv
`timescale 1ns / 1ps
// lbp_checker: port-level assertions for lru_binding_pool, plus its bind.
// Depends on lbp_pkg for field widths.
module lbp_checker
  import lbp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [SLOT_OUT_W-1:0] slot,
  input logic                  hit,
  input logic                  evicted,
  input logic                  invalidate_index_cache,
  input logic                  define_needed,
  input logic [HANDLE_W-1:0]   bind_index_handle
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(slot) && $stable(hit) && $stable(bind_index_handle))
    else $error("result changed while stalled");

  // one item in flight: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken during a lookup");

  // a define is due exactly on a miss, and always invalidates
  a_define: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (define_needed == !hit) && (!define_needed || invalidate_index_cache))
    else $error("define or invalidate inconsistent with hit");

  // eviction only on a miss
  a_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> !hit)
    else $error("eviction reported on a hit");

endmodule

bind lru_binding_pool lbp_checker u_lbp_checker (.*);

FILE: dv/lru_binding_pool_test.sv
`timescale 1ns / 1ps
// lru_binding_pool_test: self-checking regression for the LRU binding pool.
// Depends on lbp_pkg and the lru_binding_pool RTL; needs nothing else.
module lru_binding_pool_test;
  import lbp_pkg::*;

  localparam int POOL_SLOTS       = 16;   // DUT default for MAX_SLOTS
  localparam int SINK_HOLD_CYCLES = 300;  // long output stall for the backpressure test
  localparam int DRAIN_CYCLES     = 25;   // quiet time after the drain, for stray results
  localparam int KEY_TABLE_DEPTH  = 32;
  localparam logic [HANDLE_W-1:0] HANDLE_ALL_ONES = '1;
  localparam logic [KEY_W-1:0]    KEY_ALL_ONES    = '1;

  // One result item as the block reports it.
  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic                  hit;
    logic                  evicted;
    logic                  bind_changed;
    logic                  invalidate_index_cache;
    logic                  define_needed;
    logic [HANDLE_W-1:0]   bind_index_handle;
  } binding_result_t;

  // Every DUT input has a known value from time zero.
  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_we       = 1'b0;
  logic [CAP_W-1:0]      cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [KEY_W-1:0]      format_key   = '0;
  logic [HANDLE_W-1:0]   index_handle = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  hit;
  logic                  evicted;
  logic                  bind_changed;
  logic                  invalidate_index_cache;
  logic                  define_needed;
  logic [HANDLE_W-1:0]   bind_index_handle;

  lru_binding_pool #(
    .MAX_SLOTS(POOL_SLOTS)
  ) i_dut (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_we                (cfg_we),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .format_key            (format_key),
    .index_handle          (index_handle),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .slot                  (slot),
    .hit                   (hit),
    .evicted               (evicted),
    .bind_changed          (bind_changed),
    .invalidate_index_cache(invalidate_index_cache),
    .define_needed         (define_needed),
    .bind_index_handle     (bind_index_handle)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pool predictor. Mirrors the pool contents, use counter and binding as of
  // the last accepted item. Reset happens once, so the declaration values are
  // the post-reset state. Only slots below pool_fill are ever looked at.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0]   pool_keys   [POOL_SLOTS];
  logic [STAMP_W-1:0] pool_stamps [POOL_SLOTS];
  int                 pool_fill         = 0;
  logic [STAMP_W-1:0] use_count         = '0;
  int                 bound_slot_now    = 0;
  bit                 bound_now_valid   = 1'b0;
  logic [CAP_W-1:0]   pool_capacity_reg = CAP_RESET;

  binding_result_t    expected_bindings[$];  // oldest first
  int                 error_count   = 0;
  bit                 sender_steady = 1'b0;  // no gaps on the request side
  bit                 sink_steady   = 1'b0;  // no stalls on the result side
  bit                 hold_request  = 1'b0;  // asks the sink for one long stall
  logic [KEY_W-1:0]   traffic_keys [KEY_TABLE_DEPTH];

  function automatic binding_result_t predict_binding(input logic [KEY_W-1:0] key,
                                                      input logic [HANDLE_W-1:0] handle);
    binding_result_t    res;
    int                 limit;
    int                 pick;
    bit                 found;
    logic [STAMP_W-1:0] oldest;
    // capacity 0 behaves as 1, anything above the slot count saturates
    limit = (pool_capacity_reg == 0) ? 1 :
            (pool_capacity_reg > POOL_SLOTS) ? POOL_SLOTS : int'(pool_capacity_reg);
    found = 1'b0;
    pick  = 0;
    res   = '0;
    // first match in slot order
    for (int i = 0; i < pool_fill; i++) begin
      if (!found && pool_keys[i] == key) begin
        found = 1'b1;
        pick  = i;
      end
    end
    if (!found) begin
      if (pool_fill < limit) begin
        pick = pool_fill;
        pool_fill++;
      end else begin
        // full, or capacity lowered below the fill: LRU over every filled
        // slot, lowest slot on equal stamps
        oldest = pool_stamps[0];
        pick   = 0;
        for (int i = 1; i < pool_fill; i++) begin
          if (pool_stamps[i] < oldest) begin
            oldest = pool_stamps[i];
            pick   = i;
          end
        end
        res.evicted = 1'b1;
      end
      pool_keys[pick] = key;
    end
    res.slot                   = SLOT_OUT_W'(pick);
    res.hit                    = found;
    res.bind_changed           = !bound_now_valid || bound_slot_now != pick;
    res.invalidate_index_cache = !found || res.bind_changed;
    res.define_needed          = !found;
    res.bind_index_handle      = handle;
    bound_slot_now    = pick;
    bound_now_valid   = 1'b1;
    use_count         = use_count + STAMP_W'(1);
    pool_stamps[pick] = use_count;
    return res;
  endfunction

  // Gap length: mostly none, some short, a few long.
  function automatic int idle_length(input bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Called right after a rising edge. in_valid is left high after
  // acceptance so back-to-back items never lower and raise it in one step.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [KEY_W-1:0] key, input logic [HANDLE_W-1:0] handle);
    int gap;
    gap = idle_length(sender_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    format_key   <= key;
    index_handle <= handle;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_bindings.push_back(predict_binding(key, handle));
  endtask

  // Stop offering items and wait until every result has come back.
  task automatic settle_pool();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_bindings.size() != 0);
  endtask

  // Capacity is only changed with the pool idle.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    settle_pool();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    pool_capacity_reg = value;
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: checks each accepted result against the oldest prediction and
  // drives out_ready with random stalls, plus one long hold on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int              stall;
    binding_result_t want;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_ready) begin
        if (expected_bindings.size() == 0) begin
          error_count++;
          $display("%0t: result with none expected, expected nothing, actual slot %0d",
                   $time, slot);
        end else begin
          want = expected_bindings.pop_front();
          check_field("slot", 32'(want.slot), 32'(slot));
          check_field("hit", 32'(want.hit), 32'(hit));
          check_field("evicted", 32'(want.evicted), 32'(evicted));
          check_field("bind_changed", 32'(want.bind_changed), 32'(bind_changed));
          check_field("invalidate_index_cache", 32'(want.invalidate_index_cache),
                      32'(invalidate_index_cache));
          check_field("define_needed", 32'(want.define_needed), 32'(define_needed));
          check_field("bind_index_handle", want.bind_index_handle, bind_index_handle);
        end
      end
      if (stall == 0 && hold_request) begin
        hold_request = 1'b0;
        stall = SINK_HOLD_CYCLES;
      end else if (stall == 0 && $urandom_range(0, 3) == 0) begin
        stall = idle_length(sink_steady);
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests. Reset is never repeated, so the order matters: the small
  // capacities come first while the pool is still nearly empty.
  // ---------------------------------------------------------------------------

  // Capacity zero acts as one slot: every miss replaces slot 0 and the binding
  // never moves after the first item.
  task automatic test_capacity_zero();
    write_capacity(5'd0);
    send_request('0, '0);                                     // fill slot 0
    send_request(KEY_ALL_ONES, HANDLE_ALL_ONES);              // evict, handle all ones
    send_request(KEY_ALL_ONES, 32'hFFFF_FFFE);                // hit, same binding
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);     // evict again
  endtask

  // Three slots: fill the rest, hit to rebind, then evict the oldest stamp.
  task automatic test_small_capacity();
    write_capacity(5'd3);
    send_request(64'h5555_5555_5555_5555, 32'h5555_5555);
    send_request(64'h8000_0000_0000_0001, 32'h0000_0001);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 32'h8000_0000);     // hit slot 0, rebinds
    send_request(64'h0000_0000_0000_0001, 32'h0F0F_0F0F);     // evicts slot 1
    send_request(64'h8000_0000_0000_0001, 32'hF0F0_F0F0);     // hit slot 2
  endtask

  // Capacity above the slot count saturates; a key one bit away from a
  // resident key must miss.
  task automatic test_capacity_saturated();
    write_capacity(5'd31);
    send_request(64'h8000_0000_0000_0003, 32'h1234_5678);
    send_request(64'h0123_4567_89AB_CDEF, 32'h0000_0000);
    send_request(64'hFEDC_BA98_7654_3210, 32'hFFFF_FFFE);
    send_request(64'h0000_0000_0000_0001, 32'h7FFF_FFFF);     // hit
  endtask

  // Capacity lowered below the fill: the pool counts as full, lookups still
  // see every filled slot and eviction picks among all of them.
  task automatic test_capacity_below_fill();
    write_capacity(5'd2);
    send_request(64'h0000_0000_0000_0002, 32'h0000_0002);
    send_request(64'h0123_4567_89AB_CDEF, 32'h0000_0003);     // hit above capacity
    write_capacity(5'd1);
    send_request(64'h0000_0000_0000_0004, 32'h0000_0004);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: mostly keys from a small working set so hits, refills and
  // LRU eviction all occur, with near-miss keys (one bit flipped) and fresh
  // keys as noise.
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(input logic [CAP_W-1:0] capacity, input int items,
                                     input bit steady);
    int               working;
    int               roll;
    logic [KEY_W-1:0] key;
    logic [HANDLE_W-1:0] handle;
    write_capacity(capacity);
    sender_steady = steady;
    sink_steady   = steady;
    for (int i = 0; i < KEY_TABLE_DEPTH; i++) traffic_keys[i] = {$urandom, $urandom};
    working = $urandom_range(1, 24);
    for (int n = 0; n < items; n++) begin
      if (n % 40 == 39) working = $urandom_range(1, 24);
      roll = $urandom_range(0, 99);
      if (roll < 85)
        key = traffic_keys[$urandom_range(0, working - 1)];
      else if (roll < 93)
        key = traffic_keys[$urandom_range(0, working - 1)] ^ (64'd1 << $urandom_range(0, 63));
      else
        key = {$urandom, $urandom};
      handle = ($urandom_range(0, 9) == 0) ? '0 : HANDLE_W'($urandom);
      send_request(key, handle);
    end
  endtask

  // Sink holds off for a long stretch while the source keeps offering items,
  // so the result register fills and in_ready drops.
  task automatic test_result_backpressure();
    settle_pool();
    sender_steady = 1'b1;
    sink_steady   = 1'b0;
    hold_request  = 1'b1;
    for (int i = 0; i < KEY_TABLE_DEPTH; i++) traffic_keys[i] = {$urandom, $urandom};
    for (int n = 0; n < 60; n++)
      send_request(traffic_keys[$urandom_range(0, 19)], HANDLE_W'($urandom));
    sender_steady = 1'b0;
  endtask

  initial begin : regression
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_capacity_zero();
    test_small_capacity();
    test_capacity_saturated();
    test_capacity_below_fill();

    test_random_traffic(5'd16, 110, 1'b0);
    test_random_traffic(5'd1, 110, 1'b0);
    test_random_traffic(5'd16, 110, 1'b1);
    test_random_traffic(5'd0, 100, 1'b0);
    test_random_traffic(5'd31, 110, 1'b0);
    test_result_backpressure();
    test_random_traffic(5'd8, 110, 1'b0);
    test_random_traffic(CAP_W'($urandom_range(0, 31)), 110, 1'b1);
    test_random_traffic(5'd4, 110, 1'b0);
    test_random_traffic(CAP_W'($urandom_range(0, 31)), 110, 1'b0);
    test_random_traffic(5'd16, 100, 1'b0);

    // drain, then leave room for any stray result to show up
    settle_pool();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("lru_binding_pool regression: pass");
    else
      $display("lru_binding_pool regression: fail");
    $finish;
  end

  // Hang guard, far above the slowest legal run.
  initial begin : watchdog
    #4_000_000;
    $display("lru_binding_pool regression: fail");
    $finish;
  end

endmodule
